// ===== design/egcd_pkg.sv =====
// egcd_pkg: shared types for the extended gcd unit.
// No dependencies.
package egcd_pkg;
    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic div_start; // begin quotient division
        logic div_step;  // one restoring division step
        logic update;    // rotate remainder/coefficient rows
    } t_cmd;
    // status from datapath to controller
    typedef struct packed {
        logic r1_zero;   // divisor is zero, loop done
        logic div_last;  // final division step this cycle
    } t_sts;
endpackage

// ===== design/egcd_if.sv =====
// egcd_if: valid/ready channel carrying a generic payload.
// Depends on nothing.
interface egcd_if #(parameter int PW = 64) ();
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/extended_gcd_unit.sv =====
// extended_gcd_unit: top level of the extended gcd block.
// Depends on egcd_pkg, egcd_if, egcd_ctrl, egcd_dp.
//
// Computes d = gcd-style last nonzero remainder of (a, b) under truncating
// signed division, with Bezout coefficients u, v (u*a + v*b = d); inv is u
// negated when d is negative. One request at a time: each Euclid iteration
// runs a bit-serial restoring divider with the two coefficient products
// accumulated alongside, then a row update; k, the number of iterations,
// is at most 45 at 32 bits. A new request is accepted only once the
// previous result has been taken. The result holds until taken.
module extended_gcd_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    egcd_if.sink   in_ch,
    egcd_if.source out_ch
);
    egcd_pkg::t_cmd w_cmd;
    egcd_pkg::t_sts w_sts;
    logic [DATA_WIDTH-1:0] w_d, w_u, w_v, w_inv;

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    egcd_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk (i_clk),
        .i_a   (in_ch.data[DATA_WIDTH-1:0]),
        .i_b   (in_ch.data[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_d   (w_d),
        .o_u   (w_u),
        .o_v   (w_v),
        .o_inv (w_inv)
    );

    // payload order: gcd_value, coef_first, coef_second, inverse_coef
    assign out_ch.data = {w_inv, w_v, w_u, w_d};
endmodule

// ===== design/egcd_ctrl.sv =====
// egcd_ctrl: sequencer for the extended gcd loop.
// Depends on egcd_pkg.
module egcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  egcd_pkg::t_sts    i_sts,
    output egcd_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_UPD, S_DONE} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == S_CHECK) && !i_sts.r1_zero;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.update    = (r_state == S_UPD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_CHECK;
                S_CHECK: r_state <= i_sts.r1_zero ? S_DONE : S_DIV;
                S_DIV:   if (i_sts.div_last) r_state <= S_UPD;
                S_UPD:   r_state <= S_CHECK;
                S_DONE:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/egcd_dp.sv =====
// egcd_dp: remainder and coefficient registers, bit-serial divider,
// shift-add multiply for the row update. Depends on egcd_pkg.
module egcd_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  egcd_pkg::t_cmd        i_cmd,
    output egcd_pkg::t_sts        o_sts,
    output logic [DATA_WIDTH-1:0] o_d,
    output logic [DATA_WIDTH-1:0] o_u,
    output logic [DATA_WIDTH-1:0] o_v,
    output logic [DATA_WIDTH-1:0] o_inv
);
    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

    logic [DATA_WIDTH-1:0] r_r0, r_r1, r_s0, r_s1, r_t0, r_t1;
    logic [DATA_WIDTH-1:0] r_rem, r_dvd, r_dvs, r_ms, r_mt;
    logic                  r_qneg;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH:0]   n_trial;
    logic [DATA_WIDTH-1:0] n_rsh, n_mr;

    assign o_sts.r1_zero  = (r_r1 == '0);
    assign o_sts.div_last = (r_cnt == LAST);

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        n_rsh   = {r_rem[DATA_WIDTH-2:0], r_dvd[DATA_WIDTH-1]};
        n_trial = {r_rem, r_dvd[DATA_WIDTH-1]} - {1'b0, r_dvs};
        // remainder of truncating division takes the dividend's sign
        n_mr    = r_r0[DATA_WIDTH-1] ? -r_rem : r_rem;
    end

    // q*s1 and q*t1 accumulated one quotient bit per step (mod 2^W)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0 <= i_a; r_r1 <= i_b;
            r_s0 <= DATA_WIDTH'(1); r_s1 <= '0;
            r_t0 <= '0; r_t1 <= DATA_WIDTH'(1);
        end
        if (i_cmd.div_start) begin
            r_dvd  <= r_r0[DATA_WIDTH-1] ? -r_r0 : r_r0;
            r_dvs  <= r_r1[DATA_WIDTH-1] ? -r_r1 : r_r1;
            r_qneg <= r_r0[DATA_WIDTH-1] ^ r_r1[DATA_WIDTH-1];
            r_rem  <= '0;
            r_ms   <= '0;
            r_mt   <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DATA_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
            r_ms  <= {r_ms[DATA_WIDTH-2:0], 1'b0} + (n_trial[DATA_WIDTH] ? '0 : r_s1);
            r_mt  <= {r_mt[DATA_WIDTH-2:0], 1'b0} + (n_trial[DATA_WIDTH] ? '0 : r_t1);
            if (n_trial[DATA_WIDTH]) begin
                r_rem <= n_rsh;
            end else begin
                r_rem <= n_trial[DATA_WIDTH-1:0];
            end
        end
        // rotate rows; sign of q applied to products
        if (i_cmd.update) begin
            r_r0 <= r_r1; r_r1 <= n_mr;
            r_s0 <= r_s1; r_s1 <= r_qneg ? r_s0 + r_ms : r_s0 - r_ms;
            r_t0 <= r_t1; r_t1 <= r_qneg ? r_t0 + r_mt : r_t0 - r_mt;
        end
    end

    assign o_d   = r_r0;
    assign o_u   = r_s0;
    assign o_v   = r_t0;
    assign o_inv = r_r0[DATA_WIDTH-1] ? -r_s0 : r_s0;
endmodule

// ===== tb/tb_extended_gcd_unit.sv =====
// tb_extended_gcd_unit: self-checking testbench for the extended gcd unit.
// Depends on egcd_pkg, egcd_if and extended_gcd_unit. Predicts (d, u, v, inv) per
// request with a behavioral Euclid loop and checks each result in order.
`timescale 1ns / 100ps

module tb_extended_gcd_unit;
    localparam int DW        = 32;
    localparam int IDLE_MAX  = 40000;
    localparam int N_RANDOM  = 380;
    localparam logic signed [DW-1:0] MAX_POS = 32'sh7fffffff;

    // gcd_value sits in the low word of the result payload
    typedef struct packed {
        logic signed [DW-1:0] inverse_coef;
        logic signed [DW-1:0] coef_second;
        logic signed [DW-1:0] coef_first;
        logic signed [DW-1:0] gcd_value;
    } t_bezout;

    // Holds the Bezout results still owed by the block, oldest first
    class bezout_board;
        t_bezout pending_bezout[$];
        int      n_errors;
        int      n_checked;

        function void note_request(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
            longint r0, r1, s0, s1, t0, t1, q, tmp;
            t_bezout exp_res;
            r0 = a; r1 = b; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
            // truncating division on signed longint matches the block
            while (r1 != 0) begin
                q   = r0 / r1;
                tmp = r0 - q * r1; r0 = r1; r1 = tmp;
                tmp = s0 - q * s1; s0 = s1; s1 = tmp;
                tmp = t0 - q * t1; t0 = t1; t1 = tmp;
            end
            exp_res.gcd_value    = r0[DW-1:0];
            exp_res.coef_first   = s0[DW-1:0];
            exp_res.coef_second  = t0[DW-1:0];
            exp_res.inverse_coef = (r0 < 0) ? -s0[DW-1:0] : s0[DW-1:0];
            pending_bezout.push_back(exp_res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            n_errors++;
        endtask

        task check_result(t_bezout got);
            t_bezout exp_res;
            n_checked++;
            if (pending_bezout.size() == 0) begin
                report($sformatf("unexpected result d=%0d", got.gcd_value));
                return;
            end
            exp_res = pending_bezout.pop_front();
            if (got.gcd_value !== exp_res.gcd_value)
                report($sformatf("gcd %0d, want %0d", got.gcd_value, exp_res.gcd_value));
            if (got.coef_first !== exp_res.coef_first)
                report($sformatf("u %0d, want %0d", got.coef_first, exp_res.coef_first));
            if (got.coef_second !== exp_res.coef_second)
                report($sformatf("v %0d, want %0d", got.coef_second, exp_res.coef_second));
            if (got.inverse_coef !== exp_res.inverse_coef)
                report($sformatf("inv %0d, want %0d", got.inverse_coef,
                                 exp_res.inverse_coef));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;
    int   n_sent = 0;
    bezout_board board = new();

    egcd_if #(.PW(2*DW)) req_ch ();
    egcd_if #(.PW(4*DW)) res_ch ();

    extended_gcd_unit #(.DATA_WIDTH(DW)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (req_ch.sink),
        .out_ch  (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    // Monitor: record requests, check results, random ready, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                board.note_request(req_ch.data[DW-1:0], req_ch.data[2*DW-1:DW]);
            end
            if (res_ch.valid && res_ch.ready) begin
                board.check_result(t_bezout'(res_ch.data));
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_MAX);
                $display("** extended_gcd_unit: FAILED **");
                $finish;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one request and hold it until accepted; a goes in the low word
    task automatic send_request(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
        int gap;
        req_ch.data  <= {b, a};
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        n_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random operand: full range, small, or with a shared factor
    function automatic logic signed [DW-1:0] pick_operand(int mode, int factor);
        logic signed [DW-1:0] val;
        case (mode)
            0: val = $urandom_range(32'h7fffffff, 0);
            1: val = $urandom_range(200, 0);
            default: val = factor * $urandom_range(50000, 0);
        endcase
        if ($urandom_range(1)) val = -val;
        return val;
    endfunction

    task automatic run_random(int count);
        int mode;
        int factor;
        for (int k = 0; k < count; k++) begin
            mode   = $urandom_range(2);
            factor = $urandom_range(40000, 1);
            if ($urandom_range(19) == 0)
                send_request(pick_operand(mode, factor), '0);
            else
                send_request(pick_operand(mode, factor), pick_operand(mode, factor));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero operands, extremes, sign mixes, worst-case Fibonacci pair
        send_request(0, 0);
        send_request(5, 0);
        send_request(-5, 0);
        send_request(0, 7);
        send_request(0, -7);
        send_request(MAX_POS, 0);
        send_request(-MAX_POS, 0);
        send_request(MAX_POS, MAX_POS);
        send_request(MAX_POS, -MAX_POS);
        send_request(-MAX_POS, 1);
        send_request(1, -MAX_POS);
        send_request(12, -18);
        send_request(-12, 18);
        send_request(240, 46);
        send_request(-240, -46);
        send_request(MAX_POS, MAX_POS - 1);
        send_request(1836311903, 1134903170);
        send_request(-1836311903, 1134903170);
        send_request(1134903170, -1836311903);
        send_request(32'sh55555555, 32'sh2aaaaaab);

        // Random phases under different back-pressure profiles
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(N_RANDOM / 4);
        send_idle_pct = 54; recv_stall_pct = 0;  run_random(N_RANDOM / 4);
        send_idle_pct = 0;  recv_stall_pct = 54; run_random(N_RANDOM / 4);
        send_idle_pct = 22; recv_stall_pct = 22; run_random(N_RANDOM / 4);
        req_ch.valid <= 1'b0;

        while (board.pending_bezout.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 n_sent, board.n_checked, board.n_errors);
        if (board.n_errors == 0)
            $display("** extended_gcd_unit: PASSED **");
        else
            $display("** extended_gcd_unit: FAILED **");
        $finish;
    end
endmodule
